// ===== rtl/core/smb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package smb_pkg;

  // Word length of one exchange; tx_byte and rx_byte stay 8 bits wide.
  localparam int BITS_PER_WORD = 8;

  localparam int CNT_W = $clog2(2 * BITS_PER_WORD);
  localparam int POS_W = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_POLARITY   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_PHASE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MSB_FIRST        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_ENABLE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_CHIP_SELECT = 3'd4;

  typedef struct packed {
    logic       sclk_level;
    logic       mosi_level;
    logic       chip_select_n;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/spi_master_byte_shifter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_ready  start_req, tx_byte[7:0], miso_level
// output    out_valid/out_ready  sclk_level, mosi_level, chip_select_n,
//                                busy_res, done_res, rx_byte[7:0]
// config    cfg_we               cfg_index[2:0], cfg_data[0:0]
//
// One tick transfer per cycle while in_ready is high: the shifter state is updated as the
// tick is accepted, and its result is registered in the result or the skid register.
// A two-entry output stage (result register plus skid register) keeps taking
// ticks while one result waits; in_ready drops only when both entries are full.
// Synchronous active-high reset: clock low, MOSI high, chip select high, idle,
// config back to polarity 0, phase 0, MSB first, input on, auto chip select on.
module spi_master_byte_shifter (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 start_req,
  input  wire logic [7:0]                           tx_byte,
  input  wire logic                                 miso_level,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      sclk_level,
  output logic                                      mosi_level,
  output logic                                      chip_select_n,
  output logic                                      busy_res,
  output logic                                      done_res,
  output logic [7:0]                                rx_byte,
  input  wire logic                                 cfg_we,
  input  wire logic [smb_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [0:0]                           cfg_data
);

  localparam int WordW = smb_pkg::BITS_PER_WORD;
  localparam int CntW  = smb_pkg::CNT_W;
  localparam int PosW  = smb_pkg::POS_W;

  logic clock_polarity;
  logic clock_phase;
  logic msb_first;
  logic input_enable;
  logic auto_chip_select;

  logic [CntW-1:0]  phase_count, phase_count_next;
  logic [WordW-1:0] tx_shift, tx_shift_next;
  logic [WordW-1:0] rx_shift, rx_shift_next;
  logic             active, active_next;
  logic             sclk_reg, sclk_reg_next;
  logic             mosi_reg, mosi_reg_next;
  logic             cs_reg, cs_reg_next;

  smb_pkg::result_t res_next;
  smb_pkg::result_t out_res;
  smb_pkg::result_t skid_res;
  logic             out_full;
  logic             skid_full;

  logic            in_xfer;
  logic            sample;
  logic [PosW-1:0] bit_idx;
  logic [PosW-1:0] pos;
  logic            done;
  logic [7:0]      rx_out;

  assign in_ready = !skid_full;
  assign in_xfer  = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_polarity   <= 1'b0;
      clock_phase      <= 1'b0;
      msb_first        <= 1'b1;
      input_enable     <= 1'b1;
      auto_chip_select <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smb_pkg::REG_CLOCK_POLARITY:   clock_polarity   <= cfg_data[0];
        smb_pkg::REG_CLOCK_PHASE:      clock_phase      <= cfg_data[0];
        smb_pkg::REG_MSB_FIRST:        msb_first        <= cfg_data[0];
        smb_pkg::REG_INPUT_ENABLE:     input_enable     <= cfg_data[0];
        smb_pkg::REG_AUTO_CHIP_SELECT: auto_chip_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // One tick of the shifter.
  always_comb begin
    phase_count_next = phase_count;
    tx_shift_next    = tx_shift;
    rx_shift_next    = rx_shift;
    active_next      = active;
    sclk_reg_next    = sclk_reg;
    mosi_reg_next    = mosi_reg;
    cs_reg_next      = cs_reg;
    done             = 1'b0;
    rx_out           = 8'd0;
    sample           = 1'b0;
    bit_idx          = PosW'(phase_count >> 1);
    pos              = msb_first ? (PosW'(WordW - 1) - bit_idx) : bit_idx;

    if (active) begin
      if (!phase_count[0]) begin
        mosi_reg_next = tx_shift[pos];
        sample        = !clock_phase;
      end else begin
        sample        = clock_phase;
      end
      sclk_reg_next = !sclk_reg;
      if (sample && input_enable && miso_level) begin
        rx_shift_next[pos] = 1'b1;
      end
      if (phase_count == CntW'(2 * WordW - 1)) begin
        if (auto_chip_select) begin
          cs_reg_next = 1'b1;
        end
        done             = 1'b1;
        rx_out           = 8'(rx_shift_next);
        active_next      = 1'b0;
        phase_count_next = '0;
      end else begin
        phase_count_next = phase_count + CntW'(1);
      end
    end else if (start_req) begin
      tx_shift_next    = WordW'(tx_byte);
      rx_shift_next    = '0;
      sclk_reg_next    = clock_polarity;
      if (auto_chip_select) begin
        cs_reg_next = 1'b0;
      end
      phase_count_next = '0;
      active_next      = 1'b1;
    end

    res_next.sclk_level    = sclk_reg_next;
    res_next.mosi_level    = mosi_reg_next;
    res_next.chip_select_n = cs_reg_next;
    res_next.busy_res      = active_next;
    res_next.done_res      = done;
    res_next.rx_byte       = rx_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      tx_shift    <= '0;
      rx_shift    <= '0;
      active      <= 1'b0;
      sclk_reg    <= 1'b0;
      mosi_reg    <= 1'b1;
      cs_reg      <= 1'b1;
    end else if (in_xfer) begin
      phase_count <= phase_count_next;
      tx_shift    <= tx_shift_next;
      rx_shift    <= rx_shift_next;
      active      <= active_next;
      sclk_reg    <= sclk_reg_next;
      mosi_reg    <= mosi_reg_next;
      cs_reg      <= cs_reg_next;
    end
  end

  // Output stage: result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (in_xfer) begin
      if (out_full && !out_ready) begin
        skid_full <= 1'b1;
      end else begin
        out_full <= 1'b1;
      end
    end else if (out_ready) begin
      // advance the skid entry, or drop the taken result
      if (skid_full) begin
        skid_full <= 1'b0;
      end else begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (out_full && !out_ready) begin
        skid_res <= res_next;
      end else begin
        out_res <= res_next;
      end
    end else if (out_ready && skid_full) begin
      out_res <= skid_res;
    end
  end

  assign out_valid     = out_full;
  assign sclk_level    = out_res.sclk_level;
  assign mosi_level    = out_res.mosi_level;
  assign chip_select_n = out_res.chip_select_n;
  assign busy_res      = out_res.busy_res;
  assign done_res      = out_res.done_res;
  assign rx_byte       = out_res.rx_byte;

endmodule

`default_nettype wire

// ===== sim/spi_master_byte_shifter_checker.sv =====
`timescale 1ns / 1ps

module spi_master_byte_shifter_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            start_req,
  input  logic [7:0]                      tx_byte,
  input  logic                            miso_level,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            sclk_level,
  input  logic                            mosi_level,
  input  logic                            chip_select_n,
  input  logic                            busy_res,
  input  logic                            done_res,
  input  logic [7:0]                      rx_byte,
  input  logic                            cfg_we,
  input  logic [smb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [0:0]                      cfg_data,
  output int                              fail_count,
  output int                              pending
);

  // shifter settings
  logic clk_pol;
  logic clk_pha;
  logic msb_order;
  logic miso_en;
  logic auto_cs;

  // shifter state
  int          half_count;
  logic [31:0] tx_word;
  logic [31:0] rx_word;
  logic        word_active;
  logic        sclk_q;
  logic        mosi_q;
  logic        cs_q;

  smb_pkg::result_t pin_states_due[$];
  smb_pkg::result_t seen;
  smb_pkg::result_t want;

  task automatic report(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp);
    if (got !== exp)
      report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp));
  endtask

  // One half-bit tick of the shifter; returns the pin levels after it.
  task automatic shift_tick(input logic start, input logic [7:0] data, input logic miso,
                            output smb_pkg::result_t r);
    int   bit_num;
    int   pos;
    logic take;
    r = '0;
    if (word_active) begin
      bit_num = half_count >> 1;
      pos = msb_order ? (smb_pkg::BITS_PER_WORD - 1 - bit_num) : bit_num;
      pos = pos & 31;
      if (half_count % 2 == 0) begin
        mosi_q = tx_word[pos];
        take = !clk_pha;
      end else begin
        take = clk_pha;
      end
      sclk_q = ~sclk_q;
      if (take && miso_en && miso)
        rx_word[pos] = 1'b1;
      half_count++;
      if (half_count >= 2 * smb_pkg::BITS_PER_WORD) begin
        if (auto_cs)
          cs_q = 1'b1;
        r.done_res = 1'b1;
        r.rx_byte = rx_word[7:0];
        word_active = 1'b0;
        half_count = 0;
      end
    end else if (start) begin
      tx_word = {24'b0, data};
      rx_word = '0;
      sclk_q = clk_pol;
      if (auto_cs)
        cs_q = 1'b0;
      half_count = 0;
      word_active = 1'b1;
    end
    r.sclk_level = sclk_q;
    r.mosi_level = mosi_q;
    r.chip_select_n = cs_q;
    r.busy_res = word_active;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      clk_pol = 1'b0;
      clk_pha = 1'b0;
      msb_order = 1'b1;
      miso_en = 1'b1;
      auto_cs = 1'b1;
      half_count = 0;
      tx_word = '0;
      rx_word = '0;
      word_active = 1'b0;
      sclk_q = 1'b0;
      mosi_q = 1'b1;
      cs_q = 1'b1;
      pin_states_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          smb_pkg::REG_CLOCK_POLARITY:   clk_pol = cfg_data[0];
          smb_pkg::REG_CLOCK_PHASE:      clk_pha = cfg_data[0];
          smb_pkg::REG_MSB_FIRST:        msb_order = cfg_data[0];
          smb_pkg::REG_INPUT_ENABLE:     miso_en = cfg_data[0];
          smb_pkg::REG_AUTO_CHIP_SELECT: auto_cs = cfg_data[0];
          default: ;
        endcase
      end
      // results are registered behind their tick, so drain before adding
      if (out_valid && out_ready) begin
        if (pin_states_due.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = pin_states_due.pop_front();
          seen = '{sclk_level, mosi_level, chip_select_n, busy_res, done_res, rx_byte};
          check_field("sclk_level", 8'(seen.sclk_level), 8'(want.sclk_level));
          check_field("mosi_level", 8'(seen.mosi_level), 8'(want.mosi_level));
          check_field("chip_select_n", 8'(seen.chip_select_n), 8'(want.chip_select_n));
          check_field("busy_res", 8'(seen.busy_res), 8'(want.busy_res));
          check_field("done_res", 8'(seen.done_res), 8'(want.done_res));
          check_field("rx_byte", seen.rx_byte, want.rx_byte);
        end
      end
      if (in_valid && in_ready) begin
        shift_tick(start_req, tx_byte, miso_level, want);
        pin_states_due.push_back(want);
      end
    end
    pending = pin_states_due.size();
  end

endmodule

// ===== sim/spi_master_byte_shifter_tb.sv =====
`timescale 1ns / 1ps

module spi_master_byte_shifter_tb;

  localparam int PHASES = 12;
  localparam int TICKS_PER_PHASE = 150;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int HOLD_OFF_AT = 400;
  localparam logic [smb_pkg::CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = 3'd7;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            start_req = 1'b0;
  logic [7:0]                      tx_byte = 8'h00;
  logic                            miso_level = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            sclk_level;
  logic                            mosi_level;
  logic                            chip_select_n;
  logic                            busy_res;
  logic                            done_res;
  logic [7:0]                      rx_byte;
  logic                            cfg_we = 1'b0;
  logic [smb_pkg::CFG_INDEX_W-1:0] cfg_index = smb_pkg::REG_CLOCK_POLARITY;
  logic [0:0]                      cfg_data = 1'b0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int delivered = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  spi_master_byte_shifter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_req(start_req), .tx_byte(tx_byte), .miso_level(miso_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .sclk_level(sclk_level), .mosi_level(mosi_level), .chip_select_n(chip_select_n),
    .busy_res(busy_res), .done_res(done_res), .rx_byte(rx_byte),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  spi_master_byte_shifter_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_req(start_req), .tx_byte(tx_byte), .miso_level(miso_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .sclk_level(sclk_level), .mosi_level(mosi_level), .chip_select_n(chip_select_n),
    .busy_res(busy_res), .done_res(done_res), .rx_byte(rx_byte),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: random backpressure plus one long hold-off to fill the output stage.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && delivered >= HOLD_OFF_AT) begin
      out_ready <= 1'b0;
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready)
        delivered <= delivered + 1;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("spi_master_byte_shifter test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one tick and hold it until the transfer.
  task automatic send_tick(input logic start, input logic [7:0] data, input logic miso);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    start_req <= start;
    tx_byte <= data;
    miso_level <= miso;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [smb_pkg::CFG_INDEX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic apply_settings(input logic pol, input logic pha, input logic msb,
                                input logic ien, input logic acs);
    write_reg(smb_pkg::REG_CLOCK_POLARITY, pol);
    write_reg(smb_pkg::REG_CLOCK_PHASE, pha);
    write_reg(smb_pkg::REG_MSB_FIRST, msb);
    write_reg(smb_pkg::REG_INPUT_ENABLE, ien);
    write_reg(smb_pkg::REG_AUTO_CHIP_SELECT, acs);
    // writes to an unmapped index must be dropped
    write_reg(CFG_INDEX_UNUSED, 1'($urandom_range(1)));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] data;
    int         pick;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // idle tick, a full word of ones with start held during it, idle tick
    send_tick(1'b0, 8'h00, 1'b1);
    send_tick(1'b1, 8'hFF, 1'b0);
    for (int i = 0; i < 2 * smb_pkg::BITS_PER_WORD; i++)
      send_tick(1'b1, 8'h00, i[0]);
    send_tick(1'b0, 8'hFF, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 21;
        recv_idle_pct = 87;
      end else if (p < 8) begin
        send_idle_pct = 87;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // settings may change with a word still in flight inside the shifter
      case (p)
        0: apply_settings(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        1: apply_settings(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        2: apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        default: apply_settings(1'($urandom_range(1)), 1'($urandom_range(1)),
                                1'($urandom_range(1)), 1'($urandom_range(1)),
                                1'($urandom_range(1)));
      endcase
      for (int t = 0; t < TICKS_PER_PHASE; t++) begin
        pick = $urandom_range(9);
        data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        send_tick($urandom_range(99) < 60, data, 1'($urandom_range(1)));
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("spi_master_byte_shifter test passed");
    else
      $display("spi_master_byte_shifter test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/smb_pkg.sv
rtl/core/spi_master_byte_shifter.sv
sim/spi_master_byte_shifter_checker.sv
sim/spi_master_byte_shifter_tb.sv
